/* design/atrm_pkg.sv */
// Package for the modem reply matcher: status and command codes, reply
// patterns, window and buffer sizes, and the match flag struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atrm_pkg;

  localparam int DATA_CAPACITY = 64;
  localparam int WIN_LEN       = 13;
  localparam int WIN_W         = 8 * WIN_LEN;
  localparam int IDX_W         = $clog2(DATA_CAPACITY + 2);
  localparam int ADDR_W        = 7;
  localparam int TICK_W        = 16;

  localparam logic [7:0] CHR_CR = 8'h0d;
  localparam logic [7:0] CHR_FF = 8'h0c;

  localparam logic [8*3-1:0]  PAT_OK     = {"OK", CHR_CR};
  localparam logic [8*13-1:0] PAT_JOINED = {"EVENT:JOINED", CHR_CR};
  localparam logic [8*6-1:0]  PAT_ERROR  = {"ERROR", CHR_CR};
  localparam logic [8*11-1:0] PAT_LOST   = {"EVENT:LOST", CHR_CR};
  localparam logic [8*2-1:0]  PAT_CRFF   = {CHR_CR, CHR_FF};
  localparam logic [8*6-1:0]  PAT_DATA   = {CHR_CR, CHR_FF, "DATA"};

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_WAIT    = 3'd1,
    ST_OK      = 3'd2,
    ST_ERR     = 3'd3,
    ST_OVF     = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic joined;
    logic error;
    logic lost;
    logic crff;
    logic data;
  } match_t;

endpackage

`default_nettype wire

/* design/atrm_if.sv */
// Handshake channels of the reply matcher: request channel (command, byte)
// and result channel (status, flags, buffer write). Uses atrm_pkg widths.
`timescale 1ns / 1ps
`default_nettype none

interface atrm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface atrm_res_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 status;
  logic                       done_res;
  logic                       joined_flag;
  logic                       lost_flag;
  logic                       data_flag;
  logic                       buf_write;
  logic [atrm_pkg::ADDR_W-1:0] buf_addr;
  logic [7:0]                 buf_value;

  modport source (output valid, output status, output done_res, output joined_flag,
                  output lost_flag, output data_flag, output buf_write,
                  output buf_addr, output buf_value, input ready);
  modport sink (input valid, input status, input done_res, input joined_flag,
                input lost_flag, input data_flag, input buf_write,
                input buf_addr, input buf_value, output ready);
endinterface

`default_nettype wire

/* design/atrm_match.sv */
// Compares the tail of the reply window with the fixed reply strings.
// Depends on atrm_pkg for the patterns and the match_t struct.
`timescale 1ns / 1ps
`default_nettype none

module atrm_match (
  input  wire logic [atrm_pkg::WIN_W-1:0] win,
  output atrm_pkg::match_t                hits
);

  // newest byte sits in the low byte of the window
  always_comb begin
    hits.ok     = (win[$bits(atrm_pkg::PAT_OK)-1:0]     == atrm_pkg::PAT_OK);
    hits.joined = (win[$bits(atrm_pkg::PAT_JOINED)-1:0] == atrm_pkg::PAT_JOINED);
    hits.error  = (win[$bits(atrm_pkg::PAT_ERROR)-1:0]  == atrm_pkg::PAT_ERROR);
    hits.lost   = (win[$bits(atrm_pkg::PAT_LOST)-1:0]   == atrm_pkg::PAT_LOST);
    hits.crff   = (win[$bits(atrm_pkg::PAT_CRFF)-1:0]   == atrm_pkg::PAT_CRFF);
    hits.data   = (win[$bits(atrm_pkg::PAT_DATA)-1:0]   == atrm_pkg::PAT_DATA);
  end

endmodule

`default_nettype wire

/* design/at_reply_matcher_top.sv */
// Modem reply matcher: an accepted request goes into the input register, then one
// pass of window compare and state update writes its outcome into the
// result register. Throughput one request per cycle; ready drops only while
// a stalled result holds the input register. Synchronous active-high reset
// clears wait state, window, flags and valids; timeout register resets to 1000.
// Depends on atrm_pkg, atrm_if and atrm_match.
`timescale 1ns / 1ps
`default_nettype none

module at_reply_matcher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  atrm_req_if.sink         req,
  atrm_res_if.source       res
);

  localparam int IW = atrm_pkg::IDX_W;
  localparam int TW = atrm_pkg::TICK_W;

  // input register
  logic                 s1_valid;
  atrm_pkg::cmd_t       s1_cmd;
  logic [7:0]           s1_byte;

  // block state
  logic [TW-1:0]               timeout_ticks;
  logic [atrm_pkg::WIN_W-1:0]  window, window_next, window_shift;
  logic                        capturing, capturing_next;
  logic [IW-1:0]               capture_index, capture_index_next, idx_inc;
  logic [TW-1:0]               tick_count, tick_count_next, tick_inc;
  atrm_pkg::status_t           wait_status, wait_status_next;
  logic [2:0]                  event_flags, event_flags_next;

  // result fields
  logic                        done_next, wr_next;
  logic [atrm_pkg::ADDR_W-1:0] addr_next;
  logic [7:0]                  val_next;

  logic                        advance;
  logic                        ended;
  atrm_pkg::match_t            hits;

  assign advance   = s1_valid && (!res.valid || res.ready);
  assign req.ready = !s1_valid || advance;

  assign window_shift = {window[atrm_pkg::WIN_W-9:0], s1_byte};

  atrm_match u_match (
    .win  (window_shift),
    .hits (hits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= atrm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd  <= atrm_pkg::cmd_t'(req.command);
      s1_byte <= req.rx_byte;
    end
  end

  always_comb begin
    window_next        = window;
    capturing_next     = capturing;
    capture_index_next = capture_index;
    tick_count_next    = tick_count;
    wait_status_next   = wait_status;
    event_flags_next   = event_flags;
    done_next          = 1'b0;
    wr_next            = 1'b0;
    addr_next          = '0;
    val_next           = '0;
    ended              = 1'b0;
    idx_inc            = capture_index + IW'(1);
    tick_inc           = (tick_count == {TW{1'b1}}) ? tick_count : tick_count + TW'(1);

    case (s1_cmd)
      atrm_pkg::CMD_START: begin
        window_next        = '0;
        capturing_next     = 1'b0;
        capture_index_next = '0;
        tick_count_next    = '0;
        wait_status_next   = atrm_pkg::ST_WAIT;
      end
      atrm_pkg::CMD_BYTE: begin
        if (wait_status == atrm_pkg::ST_WAIT) begin
          window_next = window_shift;
          if (capturing) begin
            wr_next            = 1'b1;
            addr_next          = atrm_pkg::ADDR_W'(capture_index);
            val_next           = s1_byte;
            capture_index_next = idx_inc;
            if (idx_inc > IW'(atrm_pkg::DATA_CAPACITY)) begin
              capturing_next   = 1'b0;
              wait_status_next = atrm_pkg::ST_OVF;
              done_next        = 1'b1;
              ended            = 1'b1;
            end
          end
          if (!ended) begin
            if (hits.ok) begin
              wait_status_next = atrm_pkg::ST_OK;
              done_next        = 1'b1;
            end else begin
              if (hits.joined) event_flags_next[0] = 1'b1;
              if (hits.error) begin
                wait_status_next = atrm_pkg::ST_ERR;
                done_next        = 1'b1;
              end else begin
                if (hits.lost) event_flags_next[1] = 1'b1;
                // closing cr ff: terminator goes after the ff position
                if (capturing && hits.crff) begin
                  wr_next             = 1'b1;
                  addr_next           = atrm_pkg::ADDR_W'(capture_index_next);
                  val_next            = '0;
                  capturing_next      = 1'b0;
                  event_flags_next[2] = 1'b1;
                end
                if (hits.data) begin
                  capturing_next     = 1'b1;
                  capture_index_next = '0;
                end
              end
            end
          end
        end
      end
      atrm_pkg::CMD_TICK: begin
        if (wait_status == atrm_pkg::ST_WAIT) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            capturing_next   = 1'b0;
            wait_status_next = atrm_pkg::ST_TIMEOUT;
            done_next        = 1'b1;
          end
        end
      end
      atrm_pkg::CMD_CLEAR: begin
        event_flags_next = '0;
      end
      default: begin
        event_flags_next = event_flags;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      capturing     <= 1'b0;
      capture_index <= '0;
      tick_count    <= '0;
      wait_status   <= atrm_pkg::ST_IDLE;
      event_flags   <= '0;
    end else if (advance) begin
      window        <= window_next;
      capturing     <= capturing_next;
      capture_index <= capture_index_next;
      tick_count    <= tick_count_next;
      wait_status   <= wait_status_next;
      event_flags   <= event_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.status      <= wait_status_next;
      res.done_res    <= done_next;
      res.joined_flag <= event_flags_next[0];
      res.lost_flag   <= event_flags_next[1];
      res.data_flag   <= event_flags_next[2];
      res.buf_write   <= wr_next;
      res.buf_addr    <= addr_next;
      res.buf_value   <= val_next;
    end
  end

endmodule

`default_nettype wire

/* bench/at_reply_matcher_top_tb.sv */
// Self-checking testbench for the modem reply matcher: directed script, then random
// reply sessions under several timeout settings, with random stalls on both channels.
// Depends on atrm_pkg, atrm_if and at_reply_matcher_top.
`timescale 1ns / 1ps

module at_reply_matcher_top_tb;

  localparam int CAPACITY    = atrm_pkg::DATA_CAPACITY;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;

  localparam logic [23:0]  REPLY_OK     = {"OK", 8'h0d};
  localparam logic [103:0] REPLY_JOINED = {"EVENT:JOINED", 8'h0d};
  localparam logic [47:0]  REPLY_ERROR  = {"ERROR", 8'h0d};
  localparam logic [87:0]  REPLY_LOST   = {"EVENT:LOST", 8'h0d};
  localparam logic [15:0]  DATA_CLOSE   = 16'h0d0c;
  localparam logic [47:0]  DATA_OPEN    = {8'h0d, 8'h0c, "DATA"};

  typedef enum int {
    TXT_OK, TXT_JOINED, TXT_ERROR, TXT_LOST, TXT_DATA_OPEN, TXT_DATA_CLOSE
  } reply_text_t;

  typedef struct packed {
    atrm_pkg::status_t           status;
    logic                        done_res;
    logic                        joined_flag;
    logic                        lost_flag;
    logic                        data_flag;
    logic                        buf_write;
    logic [atrm_pkg::ADDR_W-1:0] buf_addr;
    logic [7:0]                  buf_value;
  } reply_t;

  typedef struct {
    atrm_pkg::cmd_t cmd;
    string          text;
    int             reps;
    bit             pinned;
    reply_t         want;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  atrm_req_if req_ch ();
  atrm_res_if res_ch ();

  at_reply_matcher_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  // matcher state as predicted
  logic [8*13-1:0]   win       = '0;
  bit                cap_on    = 1'b0;
  int                cap_idx   = 0;
  logic [15:0]       tick_cnt  = '0;
  atrm_pkg::status_t wstat     = atrm_pkg::ST_IDLE;
  logic [2:0]        ev_flags  = '0;
  logic [15:0]       tmo_limit = 16'd1000;

  reply_t      pending_replies[$];
  script_row_t script[$];
  int          mismatches   = 0;
  int          counted      = 0;
  int          quiet        = 0;
  bit          calm         = 1'b0;
  bit          sink_calm    = 1'b0;
  bit          hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reply_t next_reply(input atrm_pkg::cmd_t c, input logic [7:0] b);
    reply_t r;
    bit     ended;
    r = '0;
    ended = 1'b0;
    case (c)
      atrm_pkg::CMD_START: begin
        win = '0;
        cap_on = 1'b0;
        cap_idx = 0;
        tick_cnt = '0;
        wstat = atrm_pkg::ST_WAIT;
      end
      atrm_pkg::CMD_BYTE: begin
        if (wstat == atrm_pkg::ST_WAIT) begin
          win = {win[8*12-1:0], b};
          if (cap_on) begin
            r.buf_write = 1'b1;
            r.buf_addr = cap_idx[atrm_pkg::ADDR_W-1:0];
            r.buf_value = b;
            cap_idx++;
            if (cap_idx > CAPACITY) begin
              cap_on = 1'b0;
              wstat = atrm_pkg::ST_OVF;
              r.done_res = 1'b1;
              ended = 1'b1;
            end
          end
          if (!ended) begin
            if (win[23:0] == REPLY_OK) begin
              wstat = atrm_pkg::ST_OK;
              r.done_res = 1'b1;
            end else begin
              if (win == REPLY_JOINED) ev_flags[0] = 1'b1;
              if (win[47:0] == REPLY_ERROR) begin
                wstat = atrm_pkg::ST_ERR;
                r.done_res = 1'b1;
              end else begin
                if (win[87:0] == REPLY_LOST) ev_flags[1] = 1'b1;
                // closing CR FF: only the terminator goes out, the FF is dropped
                if (cap_on && win[15:0] == DATA_CLOSE) begin
                  r.buf_write = 1'b1;
                  r.buf_addr = cap_idx[atrm_pkg::ADDR_W-1:0];
                  r.buf_value = 8'h00;
                  cap_on = 1'b0;
                  ev_flags[2] = 1'b1;
                end
                if (win[47:0] == DATA_OPEN) begin
                  cap_on = 1'b1;
                  cap_idx = 0;
                end
              end
            end
          end
        end
      end
      atrm_pkg::CMD_TICK: begin
        if (wstat == atrm_pkg::ST_WAIT) begin
          if (tick_cnt != 16'hFFFF) tick_cnt++;
          if (tick_cnt >= tmo_limit) begin
            cap_on = 1'b0;
            wstat = atrm_pkg::ST_TIMEOUT;
            r.done_res = 1'b1;
          end
        end
      end
      default: ev_flags = '0;
    endcase
    r.status = wstat;
    r.joined_flag = ev_flags[0];
    r.lost_flag = ev_flags[1];
    r.data_flag = ev_flags[2];
    return r;
  endfunction

  function automatic reply_t mk_reply(atrm_pkg::status_t st, bit dn, bit j, bit l, bit d,
                                      bit wr, int a, int v);
    reply_t r;
    r.status = st;
    r.done_res = dn;
    r.joined_flag = j;
    r.lost_flag = l;
    r.data_flag = d;
    r.buf_write = wr;
    r.buf_addr = a[atrm_pkg::ADDR_W-1:0];
    r.buf_value = v[7:0];
    return r;
  endfunction

  function automatic string reply_text(reply_text_t k);
    case (k)
      TXT_OK:        return "OK\015";
      TXT_JOINED:    return "EVENT:JOINED\015";
      TXT_ERROR:     return "ERROR\015";
      TXT_LOST:      return "EVENT:LOST\015";
      TXT_DATA_OPEN: return "\015\014DATA";
      default:       return "\015\014";
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_req(atrm_pkg::cmd_t c, logic [7:0] b, bit pin = 1'b0,
                          reply_t pin_val = '0);
    int     gap;
    reply_t want;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= c;
    req_ch.rx_byte <= b;
    do @(posedge clk); while (!req_ch.ready);
    counted++;
    want = next_reply(c, b);
    pending_replies.push_back(pin ? pin_val : want);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_req(atrm_pkg::CMD_BYTE, s[i]);
  endtask

  task automatic send_random_bytes(int n);
    repeat (n) send_req(atrm_pkg::CMD_BYTE, 8'($urandom));
  endtask

  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_timeout(logic [15:0] v);
    drain_replies();
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tmo_limit = v;
  endtask

  task automatic add_step(atrm_pkg::cmd_t c, string s, int n, bit pin, reply_t w);
    script_row_t row;
    row.cmd = c;
    row.text = s;
    row.reps = n;
    row.pinned = pin;
    row.want = w;
    script.push_back(row);
  endtask

  task automatic run_script();
    int  i;
    int  k;
    int  j;
    bit  last;
    for (i = 0; i < script.size(); i++) begin
      calm = $urandom_range(0, 1);
      for (k = 0; k < script[i].reps; k++) begin
        if (script[i].cmd == atrm_pkg::CMD_BYTE) begin
          for (j = 0; j < script[i].text.len(); j++) begin
            last = script[i].pinned && k == script[i].reps - 1 &&
                   j == script[i].text.len() - 1;
            send_req(atrm_pkg::CMD_BYTE, script[i].text[j], last, script[i].want);
          end
        end else begin
          last = script[i].pinned && k == script[i].reps - 1;
          send_req(script[i].cmd, 8'($urandom), last, script[i].want);
        end
      end
    end
  endtask

  task automatic reply_session();
    int    frags;
    int    pick;
    int    k;
    int    i;
    string s;
    send_req(atrm_pkg::CMD_START, 8'($urandom));
    frags = $urandom_range(1, 8);
    for (i = 0; i < frags && wstat == atrm_pkg::ST_WAIT; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        send_random_bytes($urandom_range(1, 3));
      end else if (pick < 26) begin
        send_text(reply_text(TXT_OK));
      end else if (pick < 34) begin
        send_text(reply_text(TXT_ERROR));
      end else if (pick < 46) begin
        send_text(reply_text(TXT_JOINED));
      end else if (pick < 58) begin
        send_text(reply_text(TXT_LOST));
      end else if (pick < 74) begin
        // data block, sometimes long enough to overflow, sometimes left open
        send_text(reply_text(TXT_DATA_OPEN));
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
        send_random_bytes(k);
        if ($urandom_range(0, 4) != 0) send_text(reply_text(TXT_DATA_CLOSE));
      end else if (pick < 82) begin
        s = reply_text(reply_text_t'($urandom_range(0, 4)));
        send_text(s.substr(0, $urandom_range(0, s.len() - 2)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 6)) send_req(atrm_pkg::CMD_TICK, 8'($urandom));
      end else if (pick < 96) begin
        send_req(atrm_pkg::CMD_CLEAR, 8'($urandom));
      end else begin
        send_req(atrm_pkg::CMD_START, 8'($urandom));
      end
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      send_req(atrm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic run_traffic(int quota);
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    counted = 0;
    while (counted < quota) begin
      calm = ($urandom_range(0, 3) == 0);
      // receiver backs off for a long stretch while requests keep coming
      if (!held && counted > quota / 4) begin
        held = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!paused && counted > quota / 2) begin
        paused = 1'b1;
        drain_replies();
      end
      if ($urandom_range(0, 9) < 8) reply_session();
      else noise_burst();
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off per traffic run
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 5) == 0) stall_left = gap_len();
      end
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.status = atrm_pkg::status_t'(res_ch.status);
      got.done_res = res_ch.done_res;
      got.joined_flag = res_ch.joined_flag;
      got.lost_flag = res_ch.lost_flag;
      got.data_flag = res_ch.data_flag;
      got.buf_write = res_ch.buf_write;
      got.buf_addr = res_ch.buf_addr;
      got.buf_value = res_ch.buf_value;
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d", got.status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", want.status, got.status);
        check_field("done_res", want.done_res, got.done_res);
        check_field("joined_flag", want.joined_flag, got.joined_flag);
        check_field("lost_flag", want.lost_flag, got.lost_flag);
        check_field("data_flag", want.data_flag, got.data_flag);
        check_field("buf_write", want.buf_write, got.buf_write);
        check_field("buf_addr", want.buf_addr, got.buf_addr);
        check_field("buf_value", want.buf_value, got.buf_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = atrm_pkg::CMD_START;
    req_ch.rx_byte = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // timeout register still at its reset value here
    add_step(atrm_pkg::CMD_TICK, "", 1, 1,
             mk_reply(atrm_pkg::ST_IDLE, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "\015", 1, 1,
             mk_reply(atrm_pkg::ST_IDLE, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_CLEAR, "", 1, 1,
             mk_reply(atrm_pkg::ST_IDLE, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_START, "", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "OK\015", 1, 1,
             mk_reply(atrm_pkg::ST_OK, 1, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "A", 1, 1,
             mk_reply(atrm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_START, "", 1, 0, '0);
    add_step(atrm_pkg::CMD_BYTE, "EVENT:JOINED\015", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 1, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "EVENT:LOST\015", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 1, 1, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "\015\014DATA", 1, 0, '0);
    add_step(atrm_pkg::CMD_BYTE, "\377\200\001", 1, 0, '0);
    add_step(atrm_pkg::CMD_BYTE, "\015\014", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 1, 1, 1, 1, 5, 0));
    add_step(atrm_pkg::CMD_CLEAR, "", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "ERROR\015", 1, 1,
             mk_reply(atrm_pkg::ST_ERR, 1, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_START, "", 1, 0, '0);
    add_step(atrm_pkg::CMD_BYTE, "\015\014DATA", 1, 0, '0);
    add_step(atrm_pkg::CMD_BYTE, "Z", CAPACITY, 0, '0);
    // one byte past capacity is still written, then the wait ends
    add_step(atrm_pkg::CMD_BYTE, "Z", 1, 1,
             mk_reply(atrm_pkg::ST_OVF, 1, 0, 0, 0, 1, CAPACITY, 8'h5a));
    add_step(atrm_pkg::CMD_START, "", 1, 0, '0);
    add_step(atrm_pkg::CMD_TICK, "", 999, 0, '0);
    add_step(atrm_pkg::CMD_TICK, "", 1, 1,
             mk_reply(atrm_pkg::ST_TIMEOUT, 1, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_START, "", 1, 0, '0);
    add_step(atrm_pkg::CMD_BYTE, "O", 1, 0, '0);
    // restart clears the window, so the pending "O" is lost
    add_step(atrm_pkg::CMD_START, "", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_BYTE, "K\015", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 0, 0, 0, 0, 0, 0));
    add_step(atrm_pkg::CMD_CLEAR, "", 1, 1,
             mk_reply(atrm_pkg::ST_WAIT, 0, 0, 0, 0, 0, 0, 0));
    run_script();

    set_timeout(16'd1);
    run_traffic(135);
    set_timeout(16'd0);
    run_traffic(135);
    set_timeout(16'hFFFF);
    run_traffic(135);
    set_timeout(16'($urandom_range(2, 12)));
    run_traffic(135);
    set_timeout(16'($urandom_range(1, 65535)));
    run_traffic(135);
    set_timeout(16'($urandom_range(2, 6)));
    run_traffic(135);

    drain_replies();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
